### hw/rtl/dtg_pkg.sv
// ----------------------------------------------------------------------------
// dtg_pkg
// Shared types, controller commands and despeckle arithmetic for the
// four-neighbor despeckle filter with glyph output.
// ----------------------------------------------------------------------------
package dtg_pkg;

  localparam int unsigned LevelW  = 4;
  localparam int unsigned GlyphW  = 7;
  localparam logic [LevelW-1:0] MaxLevel = 4'd9;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic shift_in;   // push accepted pixel into the raw line
    logic rotate;     // advance the raw line by one column during flush
    logic load;       // compute a result and load the output register
    logic up_vld;
    logic left_vld;
    logic right_vld;
    logic down_vld;
    logic last;       // result closes the frame
  } dtg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register empty or drained this cycle
  } dtg_status_t;

  // Clamp raw levels above nine
  function automatic logic [LevelW-1:0] sat_level(input logic [LevelW-1:0] lvl);
    sat_level = (lvl > MaxLevel) ? MaxLevel : lvl;
  endfunction

  // Glyph table, darkest to brightest
  function automatic logic [GlyphW-1:0] glyph_of(input logic [LevelW-1:0] lvl);
    logic [GlyphW-1:0] g;
    unique case (lvl)
      4'd0:    g = 7'd32;   // ' '
      4'd1:    g = 7'd46;   // '.'
      4'd2:    g = 7'd39;   // '''
      4'd3:    g = 7'd58;   // ':'
      4'd4:    g = 7'd126;  // '~'
      4'd5:    g = 7'd42;   // '*'
      4'd6:    g = 7'd61;   // '='
      4'd7:    g = 7'd38;   // '&'
      4'd8:    g = 7'd37;   // '%'
      default: g = 7'd35;   // '#'
    endcase
    return g;
  endfunction

  // Replace a pixel by the rounded mean of its neighbors when every valid
  // neighbor differs from it by more than one. nb order: up, left, right, down.
  function automatic logic [LevelW-1:0] despeckle(
    input logic [LevelW-1:0]        ctr,
    input logic [3:0][LevelW-1:0]   nb,
    input logic [3:0]               vld
  );
    logic [2:0]        n;
    logic [3:0]        far;
    logic [5:0]        sum;
    logic [LevelW-1:0] dif;
    logic [6:0]        x;
    logic [12:0]       p;
    logic [LevelW-1:0] res;
    n   = '0;
    far = '0;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      dif    = (ctr > nb[i]) ? (ctr - nb[i]) : (nb[i] - ctr);
      far[i] = vld[i] && (dif > 4'd1);
      if (vld[i]) begin
        n   = n + 3'd1;
        sum = sum + {2'b00, nb[i]};
      end
    end
    // 2*sum + n, divided by 2n below
    x   = {sum, 1'b0} + {4'b0000, n};
    p   = {6'b000000, x} * 13'd43;
    res = ctr;
    if ((vld != 4'b0000) && (far == vld)) begin
      unique case (n)
        3'd1:    res = x[4:1];
        3'd2:    res = x[5:2];
        3'd3:    res = p[11:8];  // x/6 by reciprocal 43/256, exact for x < 64
        3'd4:    res = x[6:3];
        default: res = ctr;
      endcase
    end
    return res;
  endfunction

endpackage

### hw/rtl/dtg_ctrl.sv
// ----------------------------------------------------------------------------
// dtg_ctrl
// Sequencer: tracks column, line and frame position, accepts pixels and walks
// the held line after a frame end.
// ----------------------------------------------------------------------------
module dtg_ctrl
  import dtg_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  input  dtg_status_t status_i,
  output dtg_cmd_t    cmd_o
);

  localparam int unsigned ColW = $clog2(LINE_WIDTH);
  localparam logic [ColW-1:0] LastCol = ColW'(LINE_WIDTH - 1);

  state_e          state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] fcol_q, fcol_d;
  logic            second_q, second_d;   // flush is in the final line
  logic            prior_q, prior_d;     // a full line is held
  logic            first_q, first_d;     // held line is the frame's first
  logic            accept;
  logic            emit;
  logic            step;
  logic            done;

  // Sequencing and commands
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    fcol_d    = fcol_q;
    second_d  = second_q;
    prior_d   = prior_q;
    first_d   = first_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    accept    = 1'b0;
    emit      = 1'b0;
    step      = 1'b0;
    done      = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        in_ready_o       = status_i.out_free;
        accept           = in_valid_i && status_i.out_free;
        cmd_o.shift_in   = accept;
        cmd_o.load       = accept && prior_q;
        cmd_o.up_vld     = !first_q;
        cmd_o.left_vld   = (col_q != '0);
        cmd_o.right_vld  = (col_q != LastCol);
        cmd_o.down_vld   = 1'b1;
        if (accept) begin
          if (in_last_i) begin
            state_d  = ST_FLUSH;
            fcol_d   = (col_q == LastCol) ? '0 : col_q + ColW'(1);
            second_d = (col_q == LastCol);
          end else if (col_q == LastCol) begin
            col_d   = '0;
            prior_d = 1'b1;
            if (prior_q) begin
              first_d = 1'b0;
            end
          end else begin
            col_d = col_q + ColW'(1);
          end
        end
      end
      ST_FLUSH: begin
        emit             = second_q || prior_q;
        step             = !emit || status_i.out_free;
        done             = second_q && (fcol_q == col_q);
        cmd_o.rotate     = step;
        cmd_o.load       = step && emit;
        cmd_o.up_vld     = second_q ? prior_q : !first_q;
        cmd_o.left_vld   = (fcol_q != '0);
        cmd_o.right_vld  = second_q ? (fcol_q != col_q) : (fcol_q != LastCol);
        cmd_o.down_vld   = 1'b0;
        cmd_o.last       = done;
        if (step) begin
          if (done) begin
            state_d = ST_RUN;
            col_d   = '0;
            prior_d = 1'b0;
            first_d = 1'b1;
          end else if (fcol_q == LastCol) begin
            fcol_d   = '0;
            second_d = 1'b1;
          end else begin
            fcol_d = fcol_q + ColW'(1);
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      col_q    <= '0;
      fcol_q   <= '0;
      second_q <= 1'b0;
      prior_q  <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      fcol_q   <= fcol_d;
      second_q <= second_d;
      prior_q  <= prior_d;
      first_q  <= first_d;
    end
  end

endmodule

### hw/rtl/dtg_datapath.sv
// ----------------------------------------------------------------------------
// dtg_datapath
// Raw and cleaned line shift registers, despeckle arithmetic, glyph lookup
// and the output register.
// ----------------------------------------------------------------------------
module dtg_datapath
  import dtg_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtg_cmd_t           cmd_i,
  output dtg_status_t        status_o,
  input  logic [LevelW-1:0]  level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LevelW-1:0]  out_level_o,
  output logic [GlyphW-1:0]  out_glyph_o,
  output logic               out_last_o
);

  // Index 0 holds the newest entry, LINE_WIDTH-1 the oldest
  logic [LevelW-1:0] raw_q   [LINE_WIDTH];
  logic [LevelW-1:0] clean_q [LINE_WIDTH];
  logic [LevelW-1:0] down_lvl;
  logic [LevelW-1:0] result;
  logic [LevelW-1:0] level_q;
  logic [GlyphW-1:0] glyph_q;
  logic              last_q;
  logic              valid_q;

  // Oldest raw tap is the center, next oldest its right neighbor; the oldest
  // cleaned entry lies above it and the newest to its left.
  assign down_lvl = sat_level(level_i);
  assign result   = despeckle(raw_q[LINE_WIDTH-1],
                              {down_lvl, raw_q[LINE_WIDTH-2], clean_q[0],
                               clean_q[LINE_WIDTH-1]},
                              {cmd_i.down_vld, cmd_i.right_vld, cmd_i.left_vld,
                               cmd_i.up_vld});

  assign status_o.out_free = !valid_q || out_ready_i;

  // Raw line: shift in pixels, rotate during flush
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in || cmd_i.rotate) begin
      raw_q[0] <= cmd_i.shift_in ? down_lvl : raw_q[LINE_WIDTH-1];
      for (int i = 1; i < LINE_WIDTH; i++) begin
        raw_q[i] <= raw_q[i-1];
      end
    end
  end

  // Cleaned line and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clean_q[0] <= result;
      for (int i = 1; i < LINE_WIDTH; i++) begin
        clean_q[i] <= clean_q[i-1];
      end
      level_q <= result;
      glyph_q <= glyph_of(result);
      last_q  <= cmd_i.last;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_level_o = level_q;
  assign out_glyph_o = glyph_q;
  assign out_last_o  = last_q;

endmodule

### hw/rtl/despeckle_to_glyph_filter.sv
// ----------------------------------------------------------------------------
// despeckle_to_glyph_filter
// Four-neighbor despeckle filter on a raster stream of levels 0..9, emitting
// each cleaned pixel one line later together with its display glyph.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, LINE_WIDTH per line, one per cycle unless the
// output stalls; each one releases the pixel one line above it, so results
// trail the input by one line and the first line gives no output until the
// second arrives. A pixel whose every in-frame neighbor differs from it by
// more than one becomes the rounded mean of those neighbors. Input levels
// above nine count as nine. The pixel marked tlast closes the frame: the
// block then stops taking input and walks its line shift register one
// column per cycle, emitting the held pixels and the final (possibly
// partial) line, with tlast on the last result. Output stalls hold the walk.
// Results pass through one output register, and with m_axis_tready high the
// block sustains one pixel per cycle within a frame.
module despeckle_to_glyph_filter
  import dtg_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] level, [7:4] zero
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] clean_level, [10:4] glyph, [15:11] zero
  output logic        m_axis_tlast    // frame_last
);

  dtg_cmd_t          cmd;
  dtg_status_t       status;
  logic [LevelW-1:0] out_level;
  logic [GlyphW-1:0] out_glyph;

  dtg_ctrl #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtg_datapath #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .level_i     (s_axis_tdata[LevelW-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_level_o (out_level),
    .out_glyph_o (out_glyph),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, out_glyph, out_level};

endmodule

### hw/rtl/dtg_checker.sv
// ----------------------------------------------------------------------------
// dtg_checker
// Port-level checks on the despeckle filter, bound to the top level.
// ----------------------------------------------------------------------------
module dtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Cleaned levels stay within 0..9
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd9)
    else $error("clean level out of range");

  // Blank glyph goes with level zero and the full block with level nine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[3:0] == 4'd0) == (m_axis_tdata[10:4] == 7'd32)) &&
                      ((m_axis_tdata[3:0] == 4'd9) == (m_axis_tdata[10:4] == 7'd35)))
    else $error("glyph does not match level");

  // Frame end starts a flush, so input is held off right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during flush");

endmodule

bind despeckle_to_glyph_filter dtg_checker u_dtg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for despeckle_to_glyph_filter. Raster frames of random
// length and texture go in on the slave stream. A built-in line-buffer
// predictor works out every cleaned pixel and glyph. Each output transfer is
// checked against the oldest prediction while both ends idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtg_pkg::*;

  localparam int unsigned LineW = 32;

  typedef struct {
    logic [LevelW-1:0] level;
    bit                frame_end;
    bit                hold;       // wait for all results before this transfer
  } raster_px_t;

  typedef struct {
    logic [LevelW-1:0] lvl;
    logic [GlyphW-1:0] glyph;
    bit                last;
  } clean_px_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // [3:0] level, [7:4] zero
  logic        s_axis_tlast = 1'b0;    // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [3:0] clean_level, [10:4] glyph, [15:11] zero
  logic        m_axis_tlast;           // frame_last

  raster_px_t  raster_q[$];
  clean_px_t   due_pixels[$];
  string       glyph_set = " .':~*=&%#";

  // Predictor state: raw line by column, cleaned line, position and flags
  logic [LevelW-1:0] raw_row [0:LineW];
  logic [LevelW-1:0] clean_row [0:LineW-1];
  int unsigned       col_n;
  int unsigned       seen_n;
  bit                top_pending;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          in_taken = 1'b0;
  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_frames = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;

  despeckle_to_glyph_filter #(
    .LINE_WIDTH(LineW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (n_errors < 20) $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // Rounded mean of the valid neighbors when all of them sit more than one
  // level away from the center; otherwise the center stays.
  function automatic logic [LevelW-1:0] mean_if_isolated(
    input logic [LevelW-1:0] ctr,
    input bit uv, input logic [LevelW-1:0] u,
    input bit lv, input logic [LevelW-1:0] l,
    input bit rv, input logic [LevelW-1:0] r,
    input bit dv, input logic [LevelW-1:0] d
  );
    logic [3:0][LevelW-1:0] nb;
    logic [3:0]             vb;
    int                     cnt;
    int                     far;
    int                     tot;
    int                     dif;
    nb  = {d, r, l, u};
    vb  = {dv, rv, lv, uv};
    cnt = 0;
    far = 0;
    tot = 0;
    for (int i = 0; i < 4; i++) begin
      if (vb[i]) begin
        cnt++;
        dif = int'(ctr) - int'(nb[i]);
        if (dif < 0) dif = -dif;
        if (dif > 1) far++;
        tot += int'(nb[i]);
      end
    end
    if (cnt == 0 || far != cnt) return ctr;
    return LevelW'((2 * tot + cnt) / (2 * cnt));
  endfunction

  task automatic push_clean(input logic [LevelW-1:0] v, input bit last);
    byte       g;
    clean_px_t e;
    g = glyph_set.getc(int'(v));
    e.lvl   = v;
    e.glyph = g[6:0];
    e.last  = last;
    due_pixels.push_back(e);
  endtask

  // One accepted pixel: release the pixel above it, flush on frame end
  task automatic predict_raster(input logic [LevelW-1:0] lvl_in, input bit fend);
    logic [LevelW-1:0] lvl;
    logic [LevelW-1:0] v;
    int unsigned       c;
    bit                prior;
    lvl   = (lvl_in > 4'd9) ? 4'd9 : lvl_in;
    c     = (col_n >= LineW) ? 0 : col_n;
    prior = (seen_n >= LineW);
    if (prior) begin
      v = mean_if_isolated(raw_row[c], !top_pending, clean_row[c],
                           c > 0, (c > 0) ? clean_row[c-1] : 4'd0,
                           c + 1 < LineW, raw_row[c+1], 1'b1, lvl);
      clean_row[c] = v;
      push_clean(v, 1'b0);
    end
    raw_row[c] = lvl;
    if (fend) begin
      // rest of the held line has no pixel below
      if (prior) begin
        for (int k = c + 1; k < LineW; k++) begin
          v = mean_if_isolated(raw_row[k], !top_pending, clean_row[k],
                               1'b1, clean_row[k-1], k + 1 < LineW, raw_row[k+1],
                               1'b0, 4'd0);
          clean_row[k] = v;
          push_clean(v, 1'b0);
        end
      end
      // then the (possibly ragged) last line
      for (int k = 0; k <= int'(c); k++) begin
        v = mean_if_isolated(raw_row[k], prior, clean_row[k],
                             k > 0, (k > 0) ? clean_row[k-1] : 4'd0,
                             k < int'(c), raw_row[k+1], 1'b0, 4'd0);
        clean_row[k] = v;
        push_clean(v, k == int'(c));
      end
      col_n       = 0;
      seen_n      = 0;
      top_pending = 1'b1;
    end else begin
      if (c + 1 >= LineW) begin
        col_n = 0;
        if (prior) top_pending = 1'b0;
      end else begin
        col_n = c + 1;
      end
      if (seen_n < LineW) seen_n++;
    end
  endtask

  // Monitor: check output transfers, then predict from input transfers
  always @(posedge clk_i) begin
    clean_px_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (due_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
        end else begin
          e = due_pixels.pop_front();
          if (m_axis_tdata[3:0] !== e.lvl)
            report_mismatch($sformatf("result %0d clean_level %0d, want %0d",
                                      n_results, m_axis_tdata[3:0], e.lvl));
          if (m_axis_tdata[10:4] !== e.glyph)
            report_mismatch($sformatf("result %0d glyph %0d, want %0d",
                                      n_results, m_axis_tdata[10:4], e.glyph));
          if (m_axis_tlast !== e.last)
            report_mismatch($sformatf("result %0d frame_last %b, want %b",
                                      n_results, m_axis_tlast, e.last));
        end
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        predict_raster(s_axis_tdata[3:0], s_axis_tlast);
        n_accepted++;
        if (s_axis_tlast) n_frames++;
      end
    end
  end

  // Driver: sender and receiver both move on the falling edge
  always @(negedge clk_i) begin
    raster_px_t px;
    bit         give;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
      if (!s_axis_tvalid || in_taken) begin
        give = (raster_q.size() != 0) && ($urandom_range(99) >= idle_pct);
        if (give && raster_q[0].hold && due_pixels.size() != 0) give = 1'b0;
        if (give) begin
          px = raster_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, px.level};
          s_axis_tlast  <= px.frame_end;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_px(input logic [LevelW-1:0] lvl, input bit fend, input bit hold);
    raster_px_t px;
    px.level     = lvl;
    px.frame_end = fend;
    px.hold      = hold;
    raster_q.push_back(px);
    n_pushed++;
  endtask

  // Random frame: mostly a textured background with speckles, some pure noise
  task automatic make_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned style;
    int          bg;
    int          t;
    bit          hold;
    logic [3:0]  v;
    kind = $urandom_range(99);
    if (kind < 20)      len = $urandom_range(31, 1);
    else if (kind < 30) len = LineW * $urandom_range(2, 1) + $urandom_range(1, 0);
    else                len = $urandom_range(130, 34);
    style = $urandom_range(9);
    bg    = int'($urandom_range(9));
    hold  = ($urandom_range(3) == 0);
    for (int i = 0; i < int'(len); i++) begin
      if (style < 2 || $urandom_range(99) < 12) begin
        v = 4'($urandom_range(15));
      end else begin
        t = bg + int'($urandom_range(2)) - 1;
        if (t < 0) t = 0;
        if (t > 9) t = 9;
        v = 4'(t);
      end
      add_px(v, i == int'(len) - 1, hold && i == 0);
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || due_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus sequence and end of run
  initial begin
    logic [3:0]  mixed [20];
    int unsigned goal;
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    mixed     = '{9, 0, 9, 0, 4, 15, 4, 4, 10, 2, 11, 3, 12, 6, 13, 7, 14, 8, 1, 5};
    idle_tab  = '{0, 78, 0, 14};
    stall_tab = '{0, 0, 78, 14};
    rst_ni = 1'b0;
    for (int k = 0; k <= int'(LineW); k++) raw_row[k] = '0;
    for (int k = 0; k < int'(LineW); k++) clean_row[k] = '0;
    col_n       = 0;
    seen_n      = 0;
    top_pending = 1'b1;

    // directed: lone pixel, two-pixel speckle, ragged line over all levels
    add_px(4'd15, 1'b1, 1'b0);
    add_px(4'd0, 1'b0, 1'b1);
    add_px(4'd9, 1'b1, 1'b0);
    for (int i = 0; i < 20; i++) add_px(mixed[i], i == 19, i == 0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_drained();

    // random frames under each handshake pressure mix
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      goal      = n_pushed + 64;
      while (n_pushed < goal) make_frame();
      wait_drained();
    end

    repeat (4 * LineW + 16) @(posedge clk_i);
    $display("Checked %0d results from %0d pixels in %0d frames,", n_results,
             n_accepted, n_frames);
    $display("including ragged flushes and random idle and stall; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dtg_pkg.sv
hw/rtl/dtg_ctrl.sv
hw/rtl/dtg_datapath.sv
hw/rtl/despeckle_to_glyph_filter.sv
hw/rtl/dtg_checker.sv
tb/tb.sv
